FILE: rtl/lagw_pkg.sv
// ----------------------------------------------------------------------------
// lagw_pkg
// Shared widths, codes and controller/datapath bundles of the lattice
// aggregation walker.
// ----------------------------------------------------------------------------
package lagw_pkg;

  localparam int OpW       = 2;
  localparam int CoordW    = 6;
  localparam int DirW      = 2;
  localparam int StatusW   = 3;
  localparam int CountW    = 13;
  localparam int GridSizeW = 7;
  localparam int StepW     = 16;
  localparam int CellW     = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  // operations
  localparam logic [OpW-1:0] OP_SEED  = 2'd0;
  localparam logic [OpW-1:0] OP_SPAWN = 2'd1;
  localparam logic [OpW-1:0] OP_MOVE  = 2'd2;

  // move directions
  localparam logic [DirW-1:0] DIR_XM = 2'd0;
  localparam logic [DirW-1:0] DIR_XP = 2'd1;
  localparam logic [DirW-1:0] DIR_YM = 2'd2;
  localparam logic [DirW-1:0] DIR_YP = 2'd3;

  // cell states
  localparam logic [CellW-1:0] CELL_EMPTY  = 2'd0;
  localparam logic [CellW-1:0] CELL_ADJ    = 2'd1;
  localparam logic [CellW-1:0] CELL_FILLED = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] ST_REJECT  = 3'd0;
  localparam logic [StatusW-1:0] ST_SEEDED  = 3'd1;
  localparam logic [StatusW-1:0] ST_SPAWNED = 3'd2;
  localparam logic [StatusW-1:0] ST_MOVED   = 3'd3;
  localparam logic [StatusW-1:0] ST_BLOCKED = 3'd4;
  localparam logic [StatusW-1:0] ST_PLACED  = 3'd5;
  localparam logic [StatusW-1:0] ST_DISCARD = 3'd6;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_GRID_SIZE      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_STEP_LIMIT     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PARTICLE_LIMIT = 2'd2;

  localparam logic [GridSizeW-1:0] GRID_SIZE_RST      = 7'd64;
  localparam logic [StepW-1:0]     STEP_LIMIT_RST     = 16'd256;
  localparam logic [CountW-1:0]    PARTICLE_LIMIT_RST = 13'd4096;

  // where a placed particle takes its coordinates from
  localparam logic [1:0] PSRC_IN  = 2'd0;
  localparam logic [1:0] PSRC_TGT = 2'd1;
  localparam logic [1:0] PSRC_POS = 2'd2;

  typedef struct packed {
    logic               clr_wr;
    logic               load_in;
    logic               probe_rd;
    logic               pos_rd;
    logic               spawn;
    logic               step_inc;
    logic               walk;
    logic               retire;
    logic               place_ld;
    logic [1:0]         place_src;
    logic               place_wr;
    logic               nb_step;
    logic               st_ld;
    logic [StatusW-1:0] st_val;
    logic               out_load;
  } lagw_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic seed_go;
    logic spawn_go;
    logic move_go;
    logic probe_filled;
    logic probe_adj;
    logic bound_ok;
    logic step_end;
    logic pos_adj;
    logic nb_last;
  } lagw_stat_t;

endpackage

FILE: rtl/lagw_if.sv
// ----------------------------------------------------------------------------
// lagw channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface lagw_in_if;
  import lagw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [CoordW-1:0] cell_x;
  logic [CoordW-1:0] cell_y;
  logic [DirW-1:0]   direction;

  modport source (output valid, output opcode, output cell_x, output cell_y,
                  output direction, input ready);
  modport sink (input valid, input opcode, input cell_x, input cell_y,
                input direction, output ready);
endinterface

interface lagw_out_if;
  import lagw_pkg::*;
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [CoordW-1:0]  walker_x;
  logic [CoordW-1:0]  walker_y;
  logic [CountW-1:0]  placed_count;
  logic               done_res;

  modport source (output valid, output status, output walker_x, output walker_y,
                  output placed_count, output done_res, input ready);
  modport sink (input valid, input status, input walker_x, input walker_y,
                input placed_count, input done_res, output ready);
endinterface

interface lagw_cfg_if;
  import lagw_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/lagw_ctrl.sv
// ----------------------------------------------------------------------------
// lagw_ctrl
// Sequencer: grid clearing sweep, operation decode, placement walk over the
// four neighbours and result hand-off.
// ----------------------------------------------------------------------------
module lagw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  lagw_pkg::lagw_stat_t stat_i,
  output lagw_pkg::lagw_cmd_t  cmd_o
);
  import lagw_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_EVAL   = 3'd3;
  localparam logic [2:0] S_END    = 3'd4;
  localparam logic [2:0] S_PLACE  = 3'd5;
  localparam logic [2:0] S_NB     = 3'd6;
  localparam logic [2:0] S_RESP   = 3'd7;

  logic [2:0] state_d, state_q;
  logic       out_valid_d, out_valid_q;
  logic       move_ok;

  assign move_ok     = stat_i.bound_ok && !stat_i.probe_filled;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.seed_go || stat_i.spawn_go || stat_i.move_go) begin
          cmd_o.probe_rd = 1'b1;
          state_d        = S_EVAL;
        end else begin
          cmd_o.st_ld  = 1'b1;
          cmd_o.st_val = ST_REJECT;
          state_d      = S_RESP;
        end
      end
      S_EVAL: begin
        // current walker cell, needed if the walk ends without moving
        cmd_o.pos_rd = 1'b1;
        cmd_o.st_ld  = 1'b1;
        state_d      = S_RESP;
        if (stat_i.seed_go) begin
          if (!stat_i.probe_filled) begin
            cmd_o.place_ld  = 1'b1;
            cmd_o.place_src = PSRC_IN;
            cmd_o.st_val    = ST_SEEDED;
            state_d         = S_PLACE;
          end else begin
            cmd_o.st_val = ST_REJECT;
          end
        end else if (stat_i.spawn_go) begin
          if (!stat_i.probe_filled) begin
            cmd_o.spawn  = 1'b1;
            cmd_o.st_val = ST_SPAWNED;
          end else begin
            cmd_o.st_val = ST_REJECT;
          end
        end else begin
          cmd_o.step_inc = 1'b1;
          cmd_o.walk     = move_ok;
          if (move_ok && stat_i.probe_adj) begin
            cmd_o.retire    = 1'b1;
            cmd_o.place_ld  = 1'b1;
            cmd_o.place_src = PSRC_TGT;
            cmd_o.st_val    = ST_PLACED;
            state_d         = S_PLACE;
          end else if (stat_i.step_end) begin
            cmd_o.retire = 1'b1;
            if (move_ok) begin
              cmd_o.st_val = ST_DISCARD;
            end else begin
              cmd_o.st_ld = 1'b0;
              state_d     = S_END;
            end
          end else begin
            cmd_o.st_val = move_ok ? ST_MOVED : ST_BLOCKED;
          end
        end
      end
      S_END: begin
        cmd_o.st_ld = 1'b1;
        if (stat_i.pos_adj) begin
          cmd_o.place_ld  = 1'b1;
          cmd_o.place_src = PSRC_POS;
          cmd_o.st_val    = ST_PLACED;
          state_d         = S_PLACE;
        end else begin
          cmd_o.st_val = ST_DISCARD;
          state_d      = S_RESP;
        end
      end
      S_PLACE: begin
        cmd_o.place_wr = 1'b1;
        state_d        = S_NB;
      end
      S_NB: begin
        cmd_o.nb_step = 1'b1;
        if (stat_i.nb_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/lagw_dp.sv
// ----------------------------------------------------------------------------
// lagw_dp
// Datapath: grid memory, walker and particle registers, configuration
// registers and the result register.
// ----------------------------------------------------------------------------
module lagw_dp #(
  parameter int GRID_SIDE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lagw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lagw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [lagw_pkg::OpW-1:0]      opcode_i,
  input  logic [lagw_pkg::CoordW-1:0]   cell_x_i,
  input  logic [lagw_pkg::CoordW-1:0]   cell_y_i,
  input  logic [lagw_pkg::DirW-1:0]     direction_i,
  input  lagw_pkg::lagw_cmd_t           cmd_i,
  output lagw_pkg::lagw_stat_t          stat_o,
  output logic [lagw_pkg::StatusW-1:0]  status_o,
  output logic [lagw_pkg::CoordW-1:0]   walker_x_o,
  output logic [lagw_pkg::CoordW-1:0]   walker_y_o,
  output logic [lagw_pkg::CountW-1:0]   placed_count_o,
  output logic                          done_res_o
);
  import lagw_pkg::*;

  localparam int SideMax = (GRID_SIDE < 64) ? GRID_SIDE : 64;
  localparam int GridCW  = $clog2(SideMax);
  localparam int AddrW   = 2 * GridCW;
  localparam int Depth   = 1 << AddrW;
  localparam logic [GridSizeW-1:0] SideMaxV = GridSizeW'(SideMax);

  function automatic logic [AddrW-1:0] cell_addr(input logic [CoordW-1:0] x,
                                                 input logic [CoordW-1:0] y);
    cell_addr = {x[GridCW-1:0], y[GridCW-1:0]};
  endfunction

  // configuration
  logic [GridSizeW-1:0] gsize_q;
  logic [StepW-1:0]     slimit_q;
  logic [CountW-1:0]    plimit_q;

  // latched input word
  logic [OpW-1:0]    op_q;
  logic [CoordW-1:0] cx_q, cy_q;
  logic [DirW-1:0]   dir_q;

  // walker and particle state
  logic [CoordW-1:0] wx_q, wy_q;
  logic              wact_q;
  logic [StepW-1:0]  step_q, step_nx;
  logic [CountW-1:0] total_q;

  // placement
  logic [CoordW-1:0] px_q, py_q;
  logic [1:0]        nb_q, rd_k;
  logic [CoordW-1:0] nbx [4];
  logic [CoordW-1:0] nby [4];
  logic [3:0]        nbok;

  logic [StatusW-1:0] st_q;
  logic [AddrW-1:0]   clr_q;

  // grid memory
  logic [CellW-1:0] grid_q [Depth];
  logic [CellW-1:0] rd_q;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [CellW-1:0] mem_wd;

  logic [GridSizeW-1:0] side;
  logic [CoordW-1:0]    tx, ty;
  logic                 bound;
  logic                 done, c_in, w_in;

  // result register
  logic [StatusW-1:0] res_st_q;
  logic [CoordW-1:0]  res_x_q, res_y_q;
  logic [CountW-1:0]  res_cnt_q;
  logic               res_done_q;

  always_comb begin
    side = gsize_q;
    if (gsize_q == '0) begin
      side = GridSizeW'(1);
    end else if (gsize_q > SideMaxV) begin
      side = SideMaxV;
    end
  end

  assign done    = total_q >= plimit_q;
  assign c_in    = ({1'b0, cx_q} < side) && ({1'b0, cy_q} < side);
  assign w_in    = ({1'b0, wx_q} < side) && ({1'b0, wy_q} < side);
  assign step_nx = step_q + StepW'(1);

  // move target
  always_comb begin
    tx    = wx_q;
    ty    = wy_q;
    bound = 1'b0;
    case (dir_q)
      DIR_XM: begin
        if (wx_q != '0) begin
          tx    = wx_q - CoordW'(1);
          bound = 1'b1;
        end
      end
      DIR_XP: begin
        if (({1'b0, wx_q} + GridSizeW'(1)) < side) begin
          tx    = wx_q + CoordW'(1);
          bound = 1'b1;
        end
      end
      DIR_YM: begin
        if (wy_q != '0) begin
          ty    = wy_q - CoordW'(1);
          bound = 1'b1;
        end
      end
      DIR_YP: begin
        if (({1'b0, wy_q} + GridSizeW'(1)) < side) begin
          ty    = wy_q + CoordW'(1);
          bound = 1'b1;
        end
      end
      default: begin
        bound = 1'b0;
      end
    endcase
  end

  // four neighbours of the placed cell
  always_comb begin
    nbx[0]  = px_q - CoordW'(1);
    nby[0]  = py_q;
    nbok[0] = px_q != '0;
    nbx[1]  = px_q + CoordW'(1);
    nby[1]  = py_q;
    nbok[1] = ({1'b0, px_q} + GridSizeW'(1)) < side;
    nbx[2]  = px_q;
    nby[2]  = py_q - CoordW'(1);
    nbok[2] = py_q != '0;
    nbx[3]  = px_q;
    nby[3]  = py_q + CoordW'(1);
    nbok[3] = ({1'b0, py_q} + GridSizeW'(1)) < side;
  end

  // neighbour k is written while neighbour k+1 is read
  assign rd_k = cmd_i.place_wr ? 2'd0 : nb_q + 2'd1;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_q;
    mem_wd = CELL_EMPTY;
    if (cmd_i.clr_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.place_wr) begin
      mem_we = 1'b1;
      mem_wa = cell_addr(px_q, py_q);
      mem_wd = CELL_FILLED;
    end else if (cmd_i.nb_step) begin
      mem_we = nbok[nb_q] && (rd_q != CELL_FILLED);
      mem_wa = cell_addr(nbx[nb_q], nby[nb_q]);
      mem_wd = CELL_ADJ;
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = cell_addr(nbx[rd_k], nby[rd_k]);
    if (cmd_i.probe_rd) begin
      mem_re = 1'b1;
      mem_ra = (op_q == OP_MOVE) ? cell_addr(tx, ty) : cell_addr(cx_q, cy_q);
    end else if (cmd_i.pos_rd) begin
      mem_re = 1'b1;
      mem_ra = cell_addr(wx_q, wy_q);
    end else if (cmd_i.place_wr || (cmd_i.nb_step && nb_q != 2'd3)) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= grid_q[mem_ra];
    end
  end

  always_comb begin
    stat_o.clr_last     = &clr_q;
    stat_o.seed_go      = !done && (op_q == OP_SEED) && c_in;
    stat_o.spawn_go     = !done && (op_q == OP_SPAWN) && c_in;
    stat_o.move_go      = !done && (op_q == OP_MOVE) && wact_q;
    stat_o.probe_filled = rd_q == CELL_FILLED;
    stat_o.probe_adj    = rd_q == CELL_ADJ;
    stat_o.bound_ok     = bound;
    stat_o.step_end     = step_nx >= slimit_q;
    stat_o.pos_adj      = w_in && (rd_q == CELL_ADJ);
    stat_o.nb_last      = nb_q == 2'd3;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsize_q  <= GRID_SIZE_RST;
      slimit_q <= STEP_LIMIT_RST;
      plimit_q <= PARTICLE_LIMIT_RST;
      wx_q     <= '0;
      wy_q     <= '0;
      wact_q   <= 1'b0;
      step_q   <= '0;
      total_q  <= '0;
      clr_q    <= '0;
      nb_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_SIZE:      gsize_q  <= cfg_data_i[GridSizeW-1:0];
          REG_STEP_LIMIT:     slimit_q <= cfg_data_i[StepW-1:0];
          REG_PARTICLE_LIMIT: plimit_q <= cfg_data_i[CountW-1:0];
          default: begin
          end
        endcase
      end
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AddrW'(1);
      end
      if (cmd_i.spawn) begin
        wx_q   <= cx_q;
        wy_q   <= cy_q;
        wact_q <= 1'b1;
        step_q <= '0;
      end
      if (cmd_i.step_inc) begin
        step_q <= step_nx;
      end
      if (cmd_i.walk) begin
        wx_q <= tx;
        wy_q <= ty;
      end
      if (cmd_i.retire) begin
        wact_q <= 1'b0;
      end
      if (cmd_i.place_wr) begin
        total_q <= total_q + CountW'(1);
        nb_q    <= '0;
      end else if (cmd_i.nb_step) begin
        nb_q <= nb_q + 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= opcode_i;
      cx_q  <= cell_x_i;
      cy_q  <= cell_y_i;
      dir_q <= direction_i;
    end
    if (cmd_i.place_ld) begin
      case (cmd_i.place_src)
        PSRC_TGT: begin
          px_q <= tx;
          py_q <= ty;
        end
        PSRC_POS: begin
          px_q <= wx_q;
          py_q <= wy_q;
        end
        default: begin
          px_q <= cx_q;
          py_q <= cy_q;
        end
      endcase
    end
    if (cmd_i.st_ld) begin
      st_q <= cmd_i.st_val;
    end
    if (cmd_i.out_load) begin
      res_st_q   <= st_q;
      res_x_q    <= (st_q == ST_SEEDED) ? cx_q : wx_q;
      res_y_q    <= (st_q == ST_SEEDED) ? cy_q : wy_q;
      res_cnt_q  <= total_q;
      res_done_q <= done;
    end
  end

  assign status_o       = res_st_q;
  assign walker_x_o     = res_x_q;
  assign walker_y_o     = res_y_q;
  assign placed_count_o = res_cnt_q;
  assign done_res_o     = res_done_q;

endmodule

FILE: rtl/lattice_aggregation_walker.sv
// ----------------------------------------------------------------------------
// lattice_aggregation_walker
// Lattice diffusion-limited aggregation engine with a single random walker.
// ----------------------------------------------------------------------------
// usage:
//   in_i   input words: opcode (seed, spawn, move), cell coordinates, direction
//   out_o  one result word per input word: status, walker or placed cell,
//          placed count, done flag
//   cfg_i  register writes (grid size, step limit, particle limit); always
//          ready, write only while no word is in flight
// after reset the grid memory is swept to empty, one cell a cycle, over all
//   2**(2*clog2(min(GRID_SIDE,64))) cells (4096 at the default); in_i.ready
//   stays low during the sweep
// each word is decoded; a word rejected there goes to the result, others
//   probe the target cell; a word rejected on a filled cell, a spawn and a
//   move that places nothing then go to the result; when a walk ends on a
//   blocked move the walker's own cell is checked and the walker is placed
//   there or discarded; placing writes the cell and then reads each of its
//   four neighbours and marks it adjacent if in the grid and not filled, one per cycle
// the result word is registered once the work is done; a word is accepted
//   while an earlier result waits, and the block holds its finished result
//   until out_o.ready frees the result register
// ----------------------------------------------------------------------------
module lattice_aggregation_walker #(
  parameter int GRID_SIDE = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  lagw_in_if.sink    in_i,
  lagw_out_if.source out_o,
  lagw_cfg_if.sink   cfg_i
);
  import lagw_pkg::*;

  lagw_cmd_t  cmd;
  lagw_stat_t stat;
  logic       cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  lagw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lagw_dp #(
    .GRID_SIDE (GRID_SIDE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .opcode_i       (in_i.opcode),
    .cell_x_i       (in_i.cell_x),
    .cell_y_i       (in_i.cell_y),
    .direction_i    (in_i.direction),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .status_o       (out_o.status),
    .walker_x_o     (out_o.walker_x),
    .walker_y_o     (out_o.walker_y),
    .placed_count_o (out_o.placed_count),
    .done_res_o     (out_o.done_res)
  );

endmodule

FILE: dv/lattice_aggregation_walker_tb.sv
// ----------------------------------------------------------------------------
// lattice_aggregation_walker_tb
// Self-checking bench for the aggregation walker. A driver feeds seed, spawn
// and move words from a queue, a predictor keeps its own grid and walker and
// queues the outcome of each accepted word, and a monitor compares every
// result word field by field. Directed corner cases come first, then random
// walks on several grid, step and particle settings, most with random stalls.
// ----------------------------------------------------------------------------
module lattice_aggregation_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lagw_pkg::*;

  localparam int GRID_SIDE = 64;
  localparam int WATCHDOG  = 20000;
  localparam int LONG_HOLD = 400;
  localparam logic [OpW-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [CoordW-1:0] cell_x;
    logic [CoordW-1:0] cell_y;
    logic [DirW-1:0]   direction;
  } cmd_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CoordW-1:0]  walker_x;
    logic [CoordW-1:0]  walker_y;
    logic [CountW-1:0]  placed_count;
    logic               done_res;
  } outcome_t;

  logic clk;
  logic rst_n;

  lagw_in_if  in_if ();
  lagw_out_if out_if ();
  lagw_cfg_if cfg_if ();

  lattice_aggregation_walker #(
    .GRID_SIDE(GRID_SIDE)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  cmd_t     cmd_q[$];
  outcome_t outcome_q[$];

  // predictor state
  logic [CellW-1:0]     cells[GRID_SIDE*GRID_SIDE];
  logic [CoordW-1:0]    walk_x;
  logic [CoordW-1:0]    walk_y;
  logic                 walking;
  logic [StepW-1:0]     step_cnt;
  logic [CountW-1:0]    placed_total;
  logic [GridSizeW-1:0] grid_cfg;
  logic [StepW-1:0]     step_cfg;
  logic [CountW-1:0]    limit_cfg;

  int  errors = 0;
  int  words_in = 0;
  int  send_idle;
  int  recv_idle;
  bit  send_hold;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  quiet = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int grid_side();
    int s;
    s = int'(grid_cfg);
    if (s < 1) s = 1;
    if (s > GRID_SIDE) s = GRID_SIDE;
    return s;
  endfunction

  function automatic void mark_near(int x, int y);
    if (cells[x*GRID_SIDE+y] != CELL_FILLED) cells[x*GRID_SIDE+y] = CELL_ADJ;
  endfunction

  function automatic void fill_cell(int x, int y);
    int s;
    s = grid_side();
    cells[x*GRID_SIDE+y] = CELL_FILLED;
    placed_total = placed_total + CountW'(1);
    if (x > 0) mark_near(x - 1, y);
    if (x + 1 < s) mark_near(x + 1, y);
    if (y > 0) mark_near(x, y - 1);
    if (y + 1 < s) mark_near(x, y + 1);
  endfunction

  function automatic void predict_word(cmd_t w);
    outcome_t r;
    int s;
    int cx;
    int cy;
    int wx;
    int wy;
    int tx;
    int ty;
    bit ok;
    bit done;
    s = grid_side();
    cx = int'(w.cell_x);
    cy = int'(w.cell_y);
    r.status = ST_REJECT;
    r.walker_x = walk_x;
    r.walker_y = walk_y;
    done = placed_total >= limit_cfg;
    if (!done && w.opcode == OP_SEED) begin
      if (cx < s && cy < s && cells[cx*GRID_SIDE+cy] != CELL_FILLED) begin
        fill_cell(cx, cy);
        r.status = ST_SEEDED;
        r.walker_x = w.cell_x;
        r.walker_y = w.cell_y;
      end
    end else if (!done && w.opcode == OP_SPAWN) begin
      if (cx < s && cy < s && cells[cx*GRID_SIDE+cy] != CELL_FILLED) begin
        walk_x = w.cell_x;
        walk_y = w.cell_y;
        walking = 1'b1;
        step_cnt = '0;
        r.status = ST_SPAWNED;
        r.walker_x = w.cell_x;
        r.walker_y = w.cell_y;
      end
    end else if (!done && w.opcode == OP_MOVE && walking) begin
      tx = int'(walk_x);
      ty = int'(walk_y);
      ok = 1'b0;
      case (w.direction)
        DIR_XM: if (tx > 0) begin
          tx = tx - 1;
          ok = 1'b1;
        end
        DIR_XP: if (tx + 1 < s) begin
          tx = tx + 1;
          ok = 1'b1;
        end
        DIR_YM: if (ty > 0) begin
          ty = ty - 1;
          ok = 1'b1;
        end
        default: if (ty + 1 < s) begin
          ty = ty + 1;
          ok = 1'b1;
        end
      endcase
      if (ok && cells[tx*GRID_SIDE+ty] == CELL_FILLED) ok = 1'b0;
      // a blocked step still counts toward the limit
      step_cnt = step_cnt + StepW'(1);
      if (ok) begin
        walk_x = CoordW'(tx);
        walk_y = CoordW'(ty);
      end
      wx = int'(walk_x);
      wy = int'(walk_y);
      if (ok && cells[tx*GRID_SIDE+ty] == CELL_ADJ) begin
        fill_cell(tx, ty);
        walking = 1'b0;
        r.status = ST_PLACED;
      end else if (step_cnt >= step_cfg) begin
        walking = 1'b0;
        if (wx < s && wy < s && cells[wx*GRID_SIDE+wy] == CELL_ADJ) begin
          fill_cell(wx, wy);
          r.status = ST_PLACED;
        end else begin
          r.status = ST_DISCARD;
        end
      end else begin
        r.status = ok ? ST_MOVED : ST_BLOCKED;
      end
      r.walker_x = walk_x;
      r.walker_y = walk_y;
    end
    r.placed_count = placed_total;
    r.done_res = placed_total >= limit_cfg;
    outcome_q.push_back(r);
  endfunction

  function automatic void add_cmd(logic [OpW-1:0] op, int x, int y, logic [DirW-1:0] d);
    cmd_t c;
    c.opcode = op;
    c.cell_x = CoordW'(x);
    c.cell_y = CoordW'(y);
    c.direction = d;
    cmd_q.push_back(c);
  endfunction

  function automatic int pick_coord(int s);
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, s - 1));
    return int'($urandom_range(0, 63));
  endfunction

  // mostly spawn-then-walk bursts, with seeds and junk words mixed in
  task automatic add_walks(int n_words);
    int cnt;
    int r;
    int len;
    int s;
    logic [31:0] junk;
    cnt = 0;
    s = grid_side();
    while (cnt < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        add_cmd(OP_SEED, pick_coord(s), pick_coord(s), DirW'($urandom_range(0, 3)));
        cnt++;
      end else if (r < 20) begin
        junk = $urandom();
        add_cmd(junk[1:0], int'(junk[7:2]), int'(junk[13:8]), junk[15:14]);
      end else begin
        add_cmd(OP_SPAWN, pick_coord(s), pick_coord(s), DirW'($urandom_range(0, 3)));
        len = $urandom_range(1, 24);
        repeat (len) add_cmd(OP_MOVE, int'($urandom_range(0, 63)),
                             int'($urandom_range(0, 63)), DirW'($urandom_range(0, 3)));
        cnt += len + 1;
      end
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_GRID_SIZE:      grid_cfg  = val[GridSizeW-1:0];
      REG_STEP_LIMIT:     step_cfg  = val[StepW-1:0];
      REG_PARTICLE_LIMIT: limit_cfg = val[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (cmd_q.size() != 0 || in_if.valid || outcome_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin : drive_words
    cmd_t nxt;
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.opcode    <= OP_SEED;
      in_if.cell_x    <= '0;
      in_if.cell_y    <= '0;
      in_if.direction <= DIR_XM;
      foreach (cells[i]) cells[i] = CELL_EMPTY;
      walk_x = '0;
      walk_y = '0;
      walking = 1'b0;
      step_cnt = '0;
      placed_total = '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_word('{in_if.opcode, in_if.cell_x, in_if.cell_y, in_if.direction});
        words_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (cmd_q.size() != 0 && !send_hold && $urandom_range(0, 99) >= send_idle) begin
          nxt = cmd_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.opcode    <= nxt.opcode;
          in_if.cell_x    <= nxt.cell_x;
          in_if.cell_y    <= nxt.cell_y;
          in_if.direction <= nxt.direction;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result word with nothing expected: status %0d", out_if.status);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            errors++;
          end
          if (out_if.walker_x !== want.walker_x) begin
            $error("walker_x: expected %0d, got %0d", want.walker_x, out_if.walker_x);
            errors++;
          end
          if (out_if.walker_y !== want.walker_y) begin
            $error("walker_y: expected %0d, got %0d", want.walker_y, out_if.walker_y);
            errors++;
          end
          if (out_if.placed_count !== want.placed_count) begin
            $error("placed_count: expected %0d, got %0d", want.placed_count,
                   out_if.placed_count);
            errors++;
          end
          if (out_if.done_res !== want.done_res) begin
            $error("done_res: expected %0d, got %0d", want.done_res, out_if.done_res);
            errors++;
          end
        end
      end
      // one long back-pressure stretch so the block fills and stalls its input
      if (!hold_done && words_in >= 60) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG) begin
        $display("lattice_aggregation_walker test failed");
        $finish;
      end
    end
  end

  initial begin
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_GRID_SIZE;
    cfg_if.data     <= '0;
    rst_n = 1'b0;
    grid_cfg = GRID_SIZE_RST;
    step_cfg = STEP_LIMIT_RST;
    limit_cfg = PARTICLE_LIMIT_RST;
    send_idle = 19;
    recv_idle = 67;
    send_hold = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // corners of the full grid on the reset settings
    add_cmd(OP_SEED, 0, 0, DIR_XM);
    add_cmd(OP_SEED, 63, 63, DIR_YP);
    add_cmd(OP_SEED, 0, 0, DIR_XM);        // already filled
    add_cmd(OP_NONE, 63, 63, DIR_YP);
    add_cmd(OP_MOVE, 5, 5, DIR_XP);        // no walker yet
    add_cmd(OP_SPAWN, 0, 0, DIR_XM);       // filled cell
    add_cmd(OP_SPAWN, 0, 2, DIR_XM);
    add_cmd(OP_MOVE, 0, 0, DIR_XM);        // grid edge
    add_cmd(OP_MOVE, 0, 0, DIR_YM);        // sticks next to the seed
    add_cmd(OP_MOVE, 0, 0, DIR_YP);        // walker gone
    add_cmd(OP_SPAWN, 63, 61, DIR_YP);
    add_cmd(OP_MOVE, 0, 0, DIR_YP);
    add_cmd(OP_SPAWN, 10, 10, DIR_XM);
    add_cmd(OP_SPAWN, 20, 20, DIR_XM);     // replaces the walker in flight
    add_cmd(OP_MOVE, 0, 0, DIR_XP);
    add_cmd(OP_MOVE, 0, 0, DIR_YM);
    add_cmd(OP_SPAWN, 1, 1, DIR_XM);
    add_cmd(OP_MOVE, 0, 0, DIR_XM);        // into a filled cell
    add_cmd(OP_MOVE, 0, 0, DIR_YM);
    add_cmd(OP_SPAWN, 62, 63, DIR_YP);
    add_cmd(OP_MOVE, 0, 0, DIR_YP);
    add_cmd(OP_MOVE, 0, 0, DIR_XP);
    wait_idle();

    // tiny grid, zero step limit
    write_reg(REG_GRID_SIZE, 16'd3);
    write_reg(REG_STEP_LIMIT, 16'd0);
    write_reg(REG_PARTICLE_LIMIT, 16'h1FFF);
    add_cmd(OP_SPAWN, 2, 2, DIR_XM);
    add_cmd(OP_MOVE, 0, 0, DIR_XM);        // walk ends away from the cluster
    add_cmd(OP_SPAWN, 2, 0, DIR_YM);
    add_cmd(OP_MOVE, 0, 0, DIR_YM);        // walk ends next to the cluster
    add_cmd(OP_SPAWN, 3, 0, DIR_XM);       // outside
    add_cmd(OP_SEED, 0, 3, DIR_XM);        // outside
    add_cmd(OP_SEED, 2, 2, DIR_XM);
    wait_idle();
    write_reg(REG_GRID_SIZE, 16'd0);
    add_cmd(OP_SPAWN, 0, 0, DIR_XM);
    add_cmd(OP_SEED, 1, 0, DIR_XM);
    add_cmd(OP_MOVE, 0, 0, DIR_XP);
    wait_idle();
    write_reg(REG_GRID_SIZE, 16'd1);
    write_reg(REG_PARTICLE_LIMIT, 16'd0);
    add_cmd(OP_SEED, 0, 0, DIR_XM);
    add_cmd(OP_SPAWN, 0, 0, DIR_XM);
    wait_idle();
    write_reg(REG_GRID_SIZE, 16'd64);
    add_cmd(OP_SEED, 40, 40, DIR_XM);      // done, so rejected
    add_cmd(OP_SPAWN, 41, 40, DIR_XM);
    wait_idle();

    // random walks on a small grid
    write_reg(REG_GRID_SIZE, 16'd8);
    write_reg(REG_STEP_LIMIT, 16'd20);
    write_reg(REG_PARTICLE_LIMIT, 16'd4096);
    add_walks(170);
    while (cmd_q.size() > 60) @(negedge clk);
    // hold the sender until the block has drained
    send_hold = 1'b1;
    while (in_if.valid || outcome_q.size() != 0) @(negedge clk);
    send_hold = 1'b0;
    wait_idle();

    // swapped stalls, long walks, limit reached partway through
    send_idle = 67;
    recv_idle = 19;
    write_reg(REG_GRID_SIZE, 16'd16);
    write_reg(REG_STEP_LIMIT, 16'hFFFF);
    write_reg(REG_PARTICLE_LIMIT, CfgDataW'(placed_total) + 16'd25);
    add_walks(170);
    wait_idle();

    // no stalls, oversized grid setting, single-step walks
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_GRID_SIZE, 16'd127);
    write_reg(REG_STEP_LIMIT, 16'd1);
    write_reg(REG_PARTICLE_LIMIT, 16'd4096);
    add_walks(160);
    wait_idle();

    if (errors == 0) begin
      $display("lattice_aggregation_walker test passed");
    end else begin
      $display("lattice_aggregation_walker test failed");
    end
    $finish;
  end

endmodule
